// ===== hdl/eqb_pkg.sv =====
// Shared types and constants of the equalizer band.
`timescale 1ns / 1ps

package eqb_pkg;

   // Fixed field widths
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 24;
   localparam int COEF_W        = 24;
   localparam int GAIN_W        = 24;
   localparam int COEF_INDEX_W  = 8;
   localparam int SAMPLE_MAX_W  = 32;
   localparam int DELAY_FIELD_W = 13;
   localparam int TAPS_FIELD_W  = 9;
   localparam int ACC_W         = 63;

   // Binary point positions of the coefficient and gain formats
   localparam int FIR_SHIFT  = 22;
   localparam int GAIN_SHIFT = 20;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_ENABLED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LINEAR_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FIR_LENGTH   = 3'd4;

   // Band modes
   localparam logic [1:0] MODE_FIR   = 2'd0;
   localparam logic [1:0] MODE_GAIN  = 2'd1;
   localparam logic [1:0] MODE_DELAY = 2'd2;

   // Register reset values
   localparam logic [1:0]               RESET_MODE = MODE_GAIN;
   localparam logic signed [GAIN_W-1:0] RESET_GAIN = 24'sd1048576;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_COEF   = 1'b1
   } opcode_type;

   // One classified item as it waits in the queue
   typedef struct packed {
      opcode_type                     op;
      logic                           last;
      logic [COEF_INDEX_W-1:0]        coef_index;
      logic signed [COEF_W-1:0]       coef_value;
      logic signed [SAMPLE_MAX_W-1:0] sample;
   } item_type;

endpackage

// ===== hdl/eqb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module eqb_ram #(
   parameter int  WIDTH = 24,
   parameter int  DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/eqb_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module eqb_front #(
   parameter int MAX_TAPS    = 256,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   input  logic [eqb_pkg::COEF_INDEX_W-1:0]       req_coef_index,
   input  logic signed [eqb_pkg::COEF_W-1:0]      req_coef_value,
   input  logic                                   req_block_last,
   output logic                                   q_valid,
   output eqb_pkg::item_type                      q_item,
   input  logic                                   q_pop
);

   eqb_pkg::item_type slot_ff [2];
   eqb_pkg::item_type item_c;
   logic [1:0] count_ff, count_in;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic       keep_c, push_c, pop_c;

   // Build the queue entry; drop coefficient writes beyond the tap store
   always_comb begin
      item_c.op         = eqb_pkg::opcode_type'(req_opcode);
      item_c.last       = req_block_last;
      item_c.coef_index = req_coef_index;
      item_c.coef_value = req_coef_value;
      item_c.sample     = eqb_pkg::SAMPLE_MAX_W'(req_sample_in);
      keep_c = (item_c.op == eqb_pkg::OP_SAMPLE) ||
               (32'(req_coef_index) < 32'(MAX_TAPS));
   end

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];
   assign push_c    = req_valid && !req_stall && keep_c;
   assign pop_c     = q_pop && q_valid;

   // Advance the queue pointers
   always_comb begin
      wr_in    = push_c ? !wr_ff : wr_ff;
      rd_in    = pop_c ? !rd_ff : rd_ff;
      count_in = 2'(count_ff + {1'b0, push_c} - {1'b0, pop_c});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (push_c) begin
         slot_ff[wr_ff] <= item_c;
      end
   end

endmodule

// ===== hdl/eqb_back.sv =====
// Back end: registers, FIR/gain/delay sequencer, clearing pass and result register.
`timescale 1ns / 1ps

module eqb_back #(
   parameter int MAX_TAPS    = 256,
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_valid,
   input  eqb_pkg::item_type                      q_item,
   output logic                                   q_pop,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [eqb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [eqb_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                   rsp_saturated,
   output logic                                   rsp_block_last_out
);

   localparam int TAW    = $clog2(MAX_TAPS);
   localparam int RING_N = 1 << TAW;
   localparam int FLW    = TAW + 1;
   localparam int DAW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int DLW    = $clog2(MAX_DELAY + 1);
   localparam int CLR_N  = (RING_N > MAX_DELAY) ? RING_N : MAX_DELAY;
   localparam int CW     = $clog2(CLR_N);
   localparam int PW     = SAMPLE_BITS + eqb_pkg::COEF_W;
   localparam int AW     = eqb_pkg::ACC_W;
   localparam int CWD    = eqb_pkg::COEF_W;

   localparam logic signed [AW-1:0] ACC_LIM  = 63'sd1 <<< 61;
   localparam logic signed [AW-1:0] SMAX     = (63'sd1 <<< (SAMPLE_BITS - 1)) - 63'sd1;
   localparam logic signed [AW-1:0] SMIN     = -(63'sd1 <<< (SAMPLE_BITS - 1));
   localparam logic signed [AW-1:0] RND_FIR  = 63'sd1 <<< (eqb_pkg::FIR_SHIFT - 1);
   localparam logic signed [AW-1:0] RND_GAIN = 63'sd1 <<< (eqb_pkg::GAIN_SHIFT - 1);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_CLEAR    = 9'b000000010,
      ST_FIR_PUT  = 9'b000000100,
      ST_FIR_RUN  = 9'b000001000,
      ST_GAIN_MUL = 9'b000010000,
      ST_ROUND    = 9'b000100000,
      ST_DLY_RD   = 9'b001000000,
      ST_DLY_WR   = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [1:0]                          mode_ff, mode_in;
   logic                                en_ff, en_in;
   logic signed [eqb_pkg::GAIN_W-1:0]   gain_ff, gain_in;
   logic [DLW-1:0]                      dlen_ff, dlen_in;
   logic [FLW-1:0]                      flen_ff, flen_in;

   // Control state
   logic [DAW-1:0] wp_ff, wp_in;
   logic [TAW-1:0] head_ff, head_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           clr_hist_ff, clr_hist_in;
   logic           clr_coef_ff, clr_coef_in;
   logic           clr_dly_ff, clr_dly_in;
   logic [FLW-1:0] tap_ff, tap_in;
   logic           rdv_ff, rdv_in;
   logic           pv_ff, pv_in;
   logic           out_v_ff, out_v_in;

   // Datapath registers
   logic signed [PW-1:0]          prod_ff, prod_in;
   logic signed [AW-1:0]          acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic                          last_ff, last_in;
   logic                          is_fir_ff, is_fir_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;
   logic                          sat_ff, sat_in;
   logic signed [SAMPLE_BITS-1:0] out_y_ff, out_y_in;
   logic                          out_sat_ff, out_sat_in;
   logic                          out_last_ff, out_last_in;

   // Memory ports
   logic                   hist_we;
   logic [TAW-1:0]         hist_wa, hist_ra;
   logic [SAMPLE_BITS-1:0] hist_wd, hist_rd;
   logic                   coef_we;
   logic [TAW-1:0]         coef_wa, coef_ra;
   logic [CWD-1:0]         coef_wd, coef_rd;
   logic                   dly_we;
   logic [DAW-1:0]         dly_wa, dly_ra;
   logic [SAMPLE_BITS-1:0] dly_wd, dly_rd;

   // Arithmetic
   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic signed [CWD-1:0]         mul_b;
   logic signed [PW-1:0]          mul_c;
   logic signed [AW-1:0]          sum_c, acc_sat_c, val_c, rnd_c;
   logic signed [SAMPLE_BITS-1:0] res_c;
   logic                          res_sat_c;
   logic [DAW-1:0]                wp_use_c, wp_nx_c;
   logic                          csr_wr_c;
   logic [31:0]                   dlen_val_c, flen_val_c;

   eqb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(RING_N)) u_hist_ram (
      .clock (clock), .we (hist_we), .waddr (hist_wa), .wdata (hist_wd),
      .raddr (hist_ra), .rdata (hist_rd)
   );

   eqb_ram #(.WIDTH(CWD), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock (clock), .we (coef_we), .waddr (coef_wa), .wdata (coef_wd),
      .raddr (coef_ra), .rdata (coef_rd)
   );

   eqb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DELAY)) u_dly_ram (
      .clock (clock), .we (dly_we), .waddr (dly_wa), .wdata (dly_wd),
      .raddr (dly_ra), .rdata (dly_rd)
   );

   // Shared multiplier: history times coefficient, or sample times gain
   always_comb begin
      if (state_ff == ST_GAIN_MUL) begin
         mul_a = x_ff;
         mul_b = gain_ff;
      end else begin
         mul_a = $signed(hist_rd);
         mul_b = $signed(coef_rd);
      end
      mul_c = PW'(mul_a) * PW'(mul_b);
   end

   // Saturating accumulate
   always_comb begin
      sum_c = acc_ff + AW'(prod_ff);
      priority if (sum_c > ACC_LIM) begin
         acc_sat_c = ACC_LIM;
      end else if (sum_c < -ACC_LIM) begin
         acc_sat_c = -ACC_LIM;
      end else begin
         acc_sat_c = sum_c;
      end
   end

   // Round to nearest and saturate to the sample width
   always_comb begin
      val_c = is_fir_ff ? acc_ff : AW'(prod_ff);
      if (is_fir_ff) begin
         rnd_c = (val_c + RND_FIR) >>> eqb_pkg::FIR_SHIFT;
      end else begin
         rnd_c = (val_c + RND_GAIN) >>> eqb_pkg::GAIN_SHIFT;
      end
      priority if (rnd_c > SMAX) begin
         res_c     = SAMPLE_BITS'(SMAX);
         res_sat_c = 1'b1;
      end else if (rnd_c < SMIN) begin
         res_c     = SAMPLE_BITS'(SMIN);
         res_sat_c = 1'b1;
      end else begin
         res_c     = SAMPLE_BITS'(rnd_c);
         res_sat_c = 1'b0;
      end
   end

   // Delay position and clamped register values
   always_comb begin
      wp_use_c = (32'(wp_ff) >= 32'(dlen_ff)) ? '0 : wp_ff;
      wp_nx_c  = (32'(wp_use_c) + 32'd1 >= 32'(dlen_ff)) ? '0 : DAW'(wp_use_c + 1'b1);
      dlen_val_c = (32'(csr_data[eqb_pkg::DELAY_FIELD_W-1:0]) > 32'(MAX_DELAY)) ?
                   32'(MAX_DELAY) : 32'(csr_data[eqb_pkg::DELAY_FIELD_W-1:0]);
      flen_val_c = (32'(csr_data[eqb_pkg::TAPS_FIELD_W-1:0]) > 32'(MAX_TAPS)) ?
                   32'(MAX_TAPS) : 32'(csr_data[eqb_pkg::TAPS_FIELD_W-1:0]);
   end

   assign csr_ready = (state_ff == ST_IDLE) || (state_ff == ST_CLEAR);
   assign csr_wr_c  = csr_valid && csr_ready;

   assign hist_ra = TAW'(head_ff - tap_ff[TAW-1:0]);
   assign coef_ra = tap_ff[TAW-1:0];
   assign dly_ra  = wp_use_c;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      en_in       = en_ff;
      gain_in     = gain_ff;
      dlen_in     = dlen_ff;
      flen_in     = flen_ff;
      wp_in       = wp_ff;
      head_in     = head_ff;
      cnt_in      = cnt_ff;
      clr_hist_in = clr_hist_ff;
      clr_coef_in = clr_coef_ff;
      clr_dly_in  = clr_dly_ff;
      tap_in      = tap_ff;
      rdv_in      = rdv_ff;
      pv_in       = pv_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      x_in        = x_ff;
      last_in     = last_ff;
      is_fir_in   = is_fir_ff;
      y_in        = y_ff;
      sat_in      = sat_ff;
      out_y_in    = out_y_ff;
      out_sat_in  = out_sat_ff;
      out_last_in = out_last_ff;
      out_v_in    = out_v_ff && rsp_stall;
      q_pop       = 1'b0;
      hist_we     = 1'b0;
      hist_wa     = cnt_ff[TAW-1:0];
      hist_wd     = '0;
      coef_we     = 1'b0;
      coef_wa     = cnt_ff[TAW-1:0];
      coef_wd     = '0;
      dly_we      = 1'b0;
      dly_wa      = cnt_ff[DAW-1:0];
      dly_wd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next item unless a register write is under way
            if (!csr_wr_c && q_valid) begin
               q_pop   = 1'b1;
               x_in    = SAMPLE_BITS'(q_item.sample);
               last_in = q_item.last;
               if (q_item.op == eqb_pkg::OP_COEF) begin
                  coef_we = 1'b1;
                  coef_wa = TAW'(q_item.coef_index);
                  coef_wd = q_item.coef_value;
               end else begin
                  priority if (en_ff && mode_ff == eqb_pkg::MODE_FIR && flen_ff != '0) begin
                     state_in = ST_FIR_PUT;
                  end else if (en_ff && mode_ff == eqb_pkg::MODE_GAIN) begin
                     state_in = ST_GAIN_MUL;
                  end else if (en_ff && mode_ff == eqb_pkg::MODE_DELAY && dlen_ff != '0) begin
                     state_in = ST_DLY_RD;
                  end else begin
                     y_in     = SAMPLE_BITS'(q_item.sample);
                     sat_in   = 1'b0;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_CLEAR: begin
            // Sweep zeros through the stores that are marked for clearing
            hist_we = clr_hist_ff && (32'(cnt_ff) < 32'(RING_N));
            coef_we = clr_coef_ff && (32'(cnt_ff) < 32'(MAX_TAPS));
            dly_we  = clr_dly_ff && (32'(cnt_ff) < 32'(MAX_DELAY));
            cnt_in  = CW'(cnt_ff + 1'b1);
            if (32'(cnt_ff) == 32'(CLR_N - 1)) begin
               state_in    = ST_IDLE;
               clr_hist_in = 1'b0;
               clr_coef_in = 1'b0;
               clr_dly_in  = 1'b0;
            end
         end
         ST_FIR_PUT: begin
            // Push the sample into the history ring
            hist_we   = 1'b1;
            hist_wa   = TAW'(head_ff + 1'b1);
            hist_wd   = x_ff;
            head_in   = TAW'(head_ff + 1'b1);
            tap_in    = '0;
            rdv_in    = 1'b0;
            pv_in     = 1'b0;
            acc_in    = '0;
            is_fir_in = 1'b1;
            state_in  = ST_FIR_RUN;
         end
         ST_FIR_RUN: begin
            // One tap a cycle: read, multiply, accumulate
            rdv_in = (tap_ff < flen_ff);
            if (tap_ff < flen_ff) begin
               tap_in = FLW'(tap_ff + 1'b1);
            end
            pv_in = rdv_ff;
            if (rdv_ff) begin
               prod_in = mul_c;
            end
            if (pv_ff) begin
               acc_in = acc_sat_c;
            end
            if (tap_ff == flen_ff && !rdv_ff && !pv_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_GAIN_MUL: begin
            prod_in   = mul_c;
            is_fir_in = 1'b0;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            y_in     = res_c;
            sat_in   = res_sat_c;
            state_in = ST_DONE;
         end
         ST_DLY_RD: begin
            state_in = ST_DLY_WR;
         end
         ST_DLY_WR: begin
            // Emit the oldest sample and overwrite it with the new one
            y_in     = $signed(dly_rd);
            sat_in   = 1'b0;
            dly_we   = 1'b1;
            dly_wa   = wp_use_c;
            dly_wd   = x_ff;
            wp_in    = wp_nx_c;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free
            if (!out_v_ff || !rsp_stall) begin
               out_v_in    = 1'b1;
               out_y_in    = y_ff;
               out_sat_in  = sat_ff;
               out_last_in = last_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes
      if (csr_wr_c) begin
         unique case (csr_index)
            eqb_pkg::REG_BAND_MODE: begin
               mode_in     = csr_data[1:0];
               wp_in       = '0;
               head_in     = '0;
               clr_hist_in = 1'b1;
               clr_dly_in  = 1'b1;
               cnt_in      = '0;
               state_in    = ST_CLEAR;
            end
            eqb_pkg::REG_BAND_ENABLED: begin
               en_in = csr_data[0];
            end
            eqb_pkg::REG_LINEAR_GAIN: begin
               gain_in = $signed(csr_data[eqb_pkg::GAIN_W-1:0]);
            end
            eqb_pkg::REG_DELAY_LENGTH: begin
               dlen_in = DLW'(dlen_val_c);
               wp_in   = '0;
            end
            eqb_pkg::REG_FIR_LENGTH: begin
               flen_in     = FLW'(flen_val_c);
               head_in     = '0;
               clr_hist_in = 1'b1;
               cnt_in      = '0;
               state_in    = ST_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         mode_ff     <= eqb_pkg::RESET_MODE;
         en_ff       <= 1'b1;
         gain_ff     <= eqb_pkg::RESET_GAIN;
         dlen_ff     <= '0;
         flen_ff     <= '0;
         wp_ff       <= '0;
         head_ff     <= '0;
         cnt_ff      <= '0;
         clr_hist_ff <= 1'b1;
         clr_coef_ff <= 1'b1;
         clr_dly_ff  <= 1'b1;
         tap_ff      <= '0;
         rdv_ff      <= 1'b0;
         pv_ff       <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         en_ff       <= en_in;
         gain_ff     <= gain_in;
         dlen_ff     <= dlen_in;
         flen_ff     <= flen_in;
         wp_ff       <= wp_in;
         head_ff     <= head_in;
         cnt_ff      <= cnt_in;
         clr_hist_ff <= clr_hist_in;
         clr_coef_ff <= clr_coef_in;
         clr_dly_ff  <= clr_dly_in;
         tap_ff      <= tap_in;
         rdv_ff      <= rdv_in;
         pv_ff       <= pv_in;
         out_v_ff    <= out_v_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      last_ff     <= last_in;
      is_fir_ff   <= is_fir_in;
      y_ff        <= y_in;
      sat_ff      <= sat_in;
      out_y_ff    <= out_y_in;
      out_sat_ff  <= out_sat_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_sample_out     = out_y_ff;
   assign rsp_saturated      = out_sat_ff;
   assign rsp_block_last_out = out_last_ff;

endmodule

// ===== hdl/eq_band_fir_gain_delay.sv =====
// Top level of the equalizer band: front-end queue and back-end sequencer.
// The FIR mode runs one tap per cycle through the shared multiplier.
// Coefficient writes give no result; one sample is processed at a time,
// and the output register frees the back end for the next item.
// Reset clears registers, then a clearing pass zeroes the stores; band_mode
// writes repeat it for the history and delay stores, fir_length writes for
// the history store alone.
`timescale 1ns / 1ps

module eq_band_fir_gain_delay #(
   parameter int MAX_TAPS    = 256,
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_opcode,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_in,
   input  logic [eqb_pkg::COEF_INDEX_W-1:0]       req_coef_index,
   input  logic signed [eqb_pkg::COEF_W-1:0]      req_coef_value,
   input  logic                                   req_block_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                                   rsp_saturated,
   output logic                                   rsp_block_last_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [eqb_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [eqb_pkg::CSR_DATA_W-1:0]         csr_data
);

   logic              q_valid;
   logic              q_pop;
   eqb_pkg::item_type q_item;

   eqb_front #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_block_last (req_block_last),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   eqb_back #(
      .MAX_TAPS    (MAX_TAPS),
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_saturated      (rsp_saturated),
      .rsp_block_last_out (rsp_block_last_out)
   );

endmodule

// ===== hdl/eqb_checker.sv =====
// Port-level checks of the equalizer band, bound to the top level.
`timescale 1ns / 1ps

module eqb_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   input logic                                rsp_saturated,
   input logic                                rsp_block_last_out
);

   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // No result survives a reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // The queue is empty after reset
   a_no_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

   // A clipped result sits at one of the rails
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_sample_out == SMAX || rsp_sample_out == SMIN))
      else $error("saturated flag without a rail value");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) &&
      $stable(rsp_saturated) && $stable(rsp_block_last_out))
      else $error("stalled result changed");

endmodule

bind eq_band_fir_gain_delay eqb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_eqb_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench of the equalizer band: FIR, gain and delay modes.
`timescale 1ns / 1ps

module tb;

   localparam int TAPS   = 256;
   localparam int DEPTH  = 4096;
   localparam int SBITS  = 24;
   localparam longint ACC_CLAMP = longint'(1) <<< 61;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic                                  req_opcode;
   logic signed [SBITS-1:0]               req_sample_in;
   logic [eqb_pkg::COEF_INDEX_W-1:0]      req_coef_index;
   logic signed [eqb_pkg::COEF_W-1:0]     req_coef_value;
   logic                                  req_block_last;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic signed [SBITS-1:0]               rsp_sample_out;
   logic                                  rsp_saturated;
   logic                                  rsp_block_last_out;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [eqb_pkg::CSR_INDEX_W-1:0]       csr_index;
   logic [eqb_pkg::CSR_DATA_W-1:0]        csr_data;

   eq_band_fir_gain_delay dut (.*);

   // Expected result of one sample item
   typedef struct {
      logic signed [SBITS-1:0] sample;
      logic                    sat;
      logic                    last;
   } band_result_type;

   band_result_type band_results[$];

   // Predictor copy of the registers and stores
   logic [1:0]                        cur_mode;
   logic                              cur_enabled;
   logic signed [eqb_pkg::GAIN_W-1:0] cur_gain;
   int                                cur_delay_len;
   int                                cur_fir_len;
   logic signed [SBITS-1:0]           fir_hist [TAPS];
   logic signed [eqb_pkg::COEF_W-1:0] fir_coef [TAPS];
   logic signed [SBITS-1:0]           delay_mem [DEPTH];
   int                                delay_pos;

   int  mismatches = 0;
   bit  no_gaps = 1'b0;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clip to the sample range, flag when clipped
   function automatic void clip(input longint v, output logic signed [SBITS-1:0] y,
                                output logic sat);
      longint hi, lo;
      hi = (longint'(1) <<< (SBITS-1)) - 1;
      lo = -(longint'(1) <<< (SBITS-1));
      sat = 1'b0;
      if (v > hi) begin
         v = hi;
         sat = 1'b1;
      end else if (v < lo) begin
         v = lo;
         sat = 1'b1;
      end
      y = v[SBITS-1:0];
   endfunction

   function automatic void clear_stores(input bit with_delay);
      foreach (fir_hist[i]) fir_hist[i] = '0;
      if (with_delay) begin
         foreach (delay_mem[i]) delay_mem[i] = '0;
         delay_pos = 0;
      end
   endfunction

   // Work out the result of one accepted item; coefficient writes give none
   function automatic void predict_band(input logic op, input logic signed [SBITS-1:0] x,
                                        input logic [7:0] idx,
                                        input logic signed [eqb_pkg::COEF_W-1:0] cv,
                                        input logic last);
      band_result_type r;
      longint acc, p;
      int wp;
      if (op == eqb_pkg::OP_COEF) begin
         fir_coef[idx] = cv;
         return;
      end
      r.sample = x;
      r.sat = 1'b0;
      r.last = last;
      if (cur_enabled) begin
         if (cur_mode == eqb_pkg::MODE_FIR && cur_fir_len > 0) begin
            for (int j = cur_fir_len - 1; j > 0; j--) fir_hist[j] = fir_hist[j-1];
            fir_hist[0] = x;
            acc = 0;
            for (int j = 0; j < cur_fir_len; j++) begin
               acc += longint'(fir_coef[j]) * longint'(fir_hist[j]);
               if (acc > ACC_CLAMP) acc = ACC_CLAMP;
               if (acc < -ACC_CLAMP) acc = -ACC_CLAMP;
            end
            clip((acc + (longint'(1) <<< (eqb_pkg::FIR_SHIFT-1))) >>> eqb_pkg::FIR_SHIFT,
                 r.sample, r.sat);
         end else if (cur_mode == eqb_pkg::MODE_GAIN) begin
            p = longint'(x) * longint'(cur_gain);
            clip((p + (longint'(1) <<< (eqb_pkg::GAIN_SHIFT-1))) >>> eqb_pkg::GAIN_SHIFT,
                 r.sample, r.sat);
         end else if (cur_mode == eqb_pkg::MODE_DELAY && cur_delay_len > 0) begin
            wp = delay_pos;
            if (wp >= cur_delay_len) wp = 0;
            r.sample = delay_mem[wp];
            delay_mem[wp] = x;
            wp++;
            if (wp >= cur_delay_len) wp = 0;
            delay_pos = wp;
         end
      end
      band_results.insert(band_results.size(), r);
   endfunction

   // Send one item, with a random gap before it
   task automatic send_item(input logic op, input logic signed [SBITS-1:0] x,
                            input logic [7:0] idx,
                            input logic signed [eqb_pkg::COEF_W-1:0] cv,
                            input logic last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_opcode     <= op;
      req_sample_in  <= x;
      req_coef_index <= idx;
      req_coef_value <= cv;
      req_block_last <= last;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_band(op, x, idx, cv, last);
   endtask

   task automatic send_sample(input logic signed [SBITS-1:0] x);
      send_item(eqb_pkg::OP_SAMPLE, x, 8'($urandom), 24'($urandom), 1'($urandom));
   endtask

   task automatic send_coef(input logic [7:0] idx,
                            input logic signed [eqb_pkg::COEF_W-1:0] cv);
      send_item(eqb_pkg::OP_COEF, 24'($urandom), idx, cv, 1'($urandom));
   endtask

   // Let every expected result drain, then let the back end settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (band_results.size() != 0) @(posedge clock);
      repeat (cur_fir_len + 40) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(input logic [eqb_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [eqb_pkg::CSR_DATA_W-1:0] val);
      int v;
      wait_idle();
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         eqb_pkg::REG_BAND_MODE: begin
            cur_mode = val[1:0];
            clear_stores(1'b1);
         end
         eqb_pkg::REG_BAND_ENABLED: cur_enabled = val[0];
         eqb_pkg::REG_LINEAR_GAIN:  cur_gain = val;
         eqb_pkg::REG_DELAY_LENGTH: begin
            v = val[12:0];
            cur_delay_len = (v > DEPTH) ? DEPTH : v;
            delay_pos = 0;
         end
         eqb_pkg::REG_FIR_LENGTH: begin
            v = val[8:0];
            cur_fir_len = (v > TAPS) ? TAPS : v;
            clear_stores(1'b0);
         end
         default: ;
      endcase
   endtask

   function automatic logic signed [SBITS-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh800000;
         1: return 24'sh7FFFFF;
         2: return 24'($urandom_range(0, 8)) - 24'sd4;
         default: return 24'($urandom);
      endcase
   endfunction

   // Hold stall for a random number of cycles before each result
   initial begin
      int k;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         k = no_gaps ? 0 : $urandom_range(0, 16);
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      band_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (band_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: sample %0d sat %0b last %0b",
                        rsp_sample_out, rsp_saturated, rsp_block_last_out);
         end else begin
            e = band_results.pop_front();
            if (rsp_sample_out !== e.sample || rsp_saturated !== e.sat ||
                rsp_block_last_out !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                           e.sample, e.sat, e.last,
                           rsp_sample_out, rsp_saturated, rsp_block_last_out);
            end
         end
      end
   end

   // Directed: reset gain of one, sample extremes
   task automatic test_reset_gain();
      send_item(eqb_pkg::OP_SAMPLE, 24'sh7FFFFF, 8'd0, 24'sd0, 1'b1);
      send_item(eqb_pkg::OP_SAMPLE, 24'sh800000, 8'hFF, 24'sh7FFFFF, 1'b0);
      send_item(eqb_pkg::OP_SAMPLE, 24'sd1, 8'd0, 24'sh800000, 1'b1);
   endtask

   // Directed: gain extremes, saturation and inversion
   task automatic test_gain_extremes();
      write_reg(eqb_pkg::REG_LINEAR_GAIN, 24'h7FFFFF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sd3);
      write_reg(eqb_pkg::REG_LINEAR_GAIN, 24'h800000);
      send_sample(24'sh800000);
      send_sample(-24'sd5);
      write_reg(eqb_pkg::REG_LINEAR_GAIN, 24'hF00000);
      send_sample(24'sh800000);
   endtask

   // Directed: FIR with longest and clamped lengths, coefficient extremes
   task automatic test_fir_lengths();
      write_reg(eqb_pkg::REG_BAND_MODE, 24'(eqb_pkg::MODE_FIR));
      send_coef(8'd0, 24'sh7FFFFF);
      send_coef(8'd1, 24'sh800000);
      send_coef(8'd255, 24'sh400000);
      send_sample(24'sd100);
      write_reg(eqb_pkg::REG_FIR_LENGTH, 24'h1FF);
      send_sample(24'sh7FFFFF);
      send_sample(24'sh7FFFFF);
      write_reg(eqb_pkg::REG_FIR_LENGTH, 24'd2);
      send_sample(24'sh800000);
      send_sample(24'sh800000);
   endtask

   // Directed: delay lengths, disabled band and the unused mode
   task automatic test_delay_passthrough();
      write_reg(eqb_pkg::REG_BAND_MODE, 24'(eqb_pkg::MODE_DELAY));
      send_sample(24'sd7);
      write_reg(eqb_pkg::REG_DELAY_LENGTH, 24'd1);
      send_sample(24'sd11);
      send_sample(24'sd12);
      write_reg(eqb_pkg::REG_DELAY_LENGTH, 24'h1FFF);
      send_sample(24'sd13);
      write_reg(eqb_pkg::REG_BAND_ENABLED, 24'd0);
      send_sample(24'sd14);
      write_reg(eqb_pkg::REG_BAND_ENABLED, 24'hFFFFFF);
      write_reg(eqb_pkg::REG_BAND_MODE, 24'd3);
      send_sample(24'sh800000);
      write_reg(3'd5, 24'($urandom));
      write_reg(3'd6, 24'($urandom));
      write_reg(3'd7, 24'($urandom));
   endtask

   // Random phases: random settings, then a run of mixed items
   task automatic test_random_phases();
      int n, mode;
      for (int ph = 0; ph < 20; ph++) begin
         no_gaps = (ph % 5 == 4);
         mode = $urandom_range(0, 3);
         write_reg(eqb_pkg::REG_BAND_MODE, 24'($urandom) & 24'hFFFFFC | 24'(mode));
         if ($urandom_range(0, 4) == 0)
            write_reg(eqb_pkg::REG_BAND_ENABLED, 24'($urandom));
         else write_reg(eqb_pkg::REG_BAND_ENABLED, 24'd1);
         write_reg(eqb_pkg::REG_LINEAR_GAIN, 24'($urandom));
         write_reg(eqb_pkg::REG_DELAY_LENGTH, ($urandom_range(0, 9) == 0) ?
                   24'($urandom) : 24'($urandom_range(0, 12)));
         write_reg(eqb_pkg::REG_FIR_LENGTH, ($urandom_range(0, 9) == 0) ?
                   24'($urandom) : 24'($urandom_range(0, 10)));
         if (mode == 0)
            for (int t = 0; t < 12; t++) send_coef(8'(t), 24'($urandom));
         n = 0;
         while (n < 25) begin
            if ($urandom_range(0, 9) == 0) begin
               send_coef(8'($urandom), 24'($urandom));
            end else begin
               send_sample(rand_sample());
               n++;
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_opcode     <= eqb_pkg::OP_SAMPLE;
      req_sample_in  <= '0;
      req_coef_index <= '0;
      req_coef_value <= '0;
      req_block_last <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      cur_mode       = eqb_pkg::RESET_MODE;
      cur_enabled    = 1'b1;
      cur_gain       = eqb_pkg::RESET_GAIN;
      cur_delay_len  = 0;
      cur_fir_len    = 0;
      foreach (fir_coef[i]) fir_coef[i] = '0;
      clear_stores(1'b1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_gain();
      test_gain_extremes();
      test_fir_lengths();
      test_delay_passthrough();
      test_random_phases();

      // Drain and settle
      wait_idle();
      if (mismatches == 0 && band_results.size() == 0) begin
         $display("eq_band_fir_gain_delay test passed");
      end else begin
         $display("eq_band_fir_gain_delay test failed");
      end
      $finish;
   end

   // Hard limit on the run
   initial begin
      #60_000_000;
      $display("eq_band_fir_gain_delay test failed");
      $finish;
   end

endmodule
